// ----- rtl/tlct_pkg.sv -----
package tlct_pkg;

  localparam int HISTORY_LINES_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int WIDE_W = 33;
  localparam int SUM_W = 21;
  localparam int CNT_W = 20;
  localparam int LINE_W = 32;
  localparam int COL_W = 16;
  localparam int KIND_W = 2;
  localparam int KEPT_W = 5;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] NL_CODE = 8'd10;
  localparam logic [SUM_W-1:0] SUM_SAT = '1;
  localparam logic [CNT_W-1:0] CHAR_SAT = '1;
  localparam logic [KEPT_W-1:0] KEPT_SAT = '1;
  localparam logic [COL_W-1:0] COL_SAT = '1;

  localparam logic [1:0] ACT_ADVANCE = 2'd0;
  localparam logic [1:0] ACT_RETREAT = 2'd1;
  localparam logic [1:0] ACT_STAT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_LOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETREAT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STAT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ADD,
    ST_SUM_END,
    ST_RET_LOOP,
    ST_RET_POP
  } state_t;

  typedef struct packed {
    logic              sub;
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
  } alu_in_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sat_sum;
    logic              borrow;
    logic [WIDE_W-1:0] diff;
  } alu_out_t;

  function automatic logic [COL_W-1:0] clamp16(input logic [WIDE_W-1:0] v);
    return (v > WIDE_W'(COL_SAT)) ? COL_SAT : v[COL_W-1:0];
  endfunction

endpackage

// ----- rtl/tlct_line_mem.sv -----
module tlct_line_mem #(
  parameter int DEPTH = tlct_pkg::HISTORY_LINES_DEF,
  parameter int WIDTH = tlct_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/tlct_alu.sv -----
module tlct_alu (
  input  tlct_pkg::alu_in_t  op,
  output tlct_pkg::alu_out_t res
);

  logic [tlct_pkg::WIDE_W:0] a_x;
  logic [tlct_pkg::WIDE_W:0] b_x;
  logic [tlct_pkg::WIDE_W:0] r;

  always_comb begin
    a_x = {1'b0, op.a};
    b_x = op.sub ? ~{1'b0, op.b} : {1'b0, op.b};
    r = a_x + b_x + (tlct_pkg::WIDE_W + 1)'(op.sub);
    res.diff = r[tlct_pkg::WIDE_W-1:0];
    res.borrow = r[tlct_pkg::WIDE_W];
    res.sat_sum = (r > (tlct_pkg::WIDE_W + 1)'(tlct_pkg::SUM_SAT)) ?
                  tlct_pkg::SUM_SAT : r[tlct_pkg::SUM_W-1:0];
  end

endmodule

// ----- rtl/text_line_column_tracker_unit.sv -----
// An advance item leaves busy low, so characters can follow one per cycle; a
// token's last character strobes a location result in the cycle after its transfer.
// A stat query reads and adds each finished line length kept in the memory, busy
// high throughout; its result is strobed as busy drops. A retreat walks them the
// same way and ends in a range error if its count exceeds the kept characters; else
// it shortens lines, popping emptied ones, until the count is used up or lines run
// out. Results cannot be stalled. Synchronous reset resets the control and position
// registers; a memory entry is always written by a newline before it is read.
module text_line_column_tracker_unit #(
  parameter int HISTORY_LINES = tlct_pkg::HISTORY_LINES_DEF,
  parameter int COUNT_BITS = tlct_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic [tlct_pkg::CHAR_W-1:0] char_code,
  input  logic                        first_of_text,
  input  logic                        last_of_text,
  input  logic [tlct_pkg::CNT_W-1:0]  retreat_count,
  output logic                        result_valid,
  output logic [tlct_pkg::KIND_W-1:0] result_kind,
  output logic [tlct_pkg::LINE_W-1:0] begin_line,
  output logic [tlct_pkg::COL_W-1:0]  begin_col,
  output logic [tlct_pkg::LINE_W-1:0] end_line,
  output logic [tlct_pkg::COL_W-1:0]  end_col,
  output logic [tlct_pkg::LINE_W-1:0] first_kept_line,
  output logic [tlct_pkg::KEPT_W-1:0] kept_line_count,
  output logic [tlct_pkg::CNT_W-1:0]  char_count,
  output logic                        range_error
);

  localparam int SLOT_W = $clog2(HISTORY_LINES);
  localparam logic [SLOT_W-1:0] LAST_OFF = SLOT_W'(HISTORY_LINES - 1);
  localparam logic [SLOT_W:0] DEPTH_X = (SLOT_W + 1)'(HISTORY_LINES);

  tlct_pkg::state_t state, state_next;

  logic [SLOT_W-1:0]           top_offset, top_offset_next;
  logic [SLOT_W-1:0]           oldest_slot, oldest_slot_next;
  logic [SLOT_W-1:0]           idx, idx_next;
  logic [tlct_pkg::LINE_W-1:0] oldest_line, oldest_line_next;
  logic [tlct_pkg::LINE_W-1:0] cur_line, cur_line_next;
  logic [COUNT_BITS-1:0]       cur_len, cur_len_next;
  logic [tlct_pkg::LINE_W-1:0] lat_line, lat_line_next;
  logic [tlct_pkg::COL_W-1:0]  lat_col, lat_col_next;
  logic [tlct_pkg::SUM_W-1:0]  acc, acc_next;
  logic [tlct_pkg::CNT_W-1:0]  rem, rem_next;
  logic                        is_stat, is_stat_next;

  logic                        result_valid_next;
  logic [tlct_pkg::KIND_W-1:0] result_kind_next;
  logic [tlct_pkg::LINE_W-1:0] begin_line_next;
  logic [tlct_pkg::COL_W-1:0]  begin_col_next;
  logic [tlct_pkg::LINE_W-1:0] end_line_next;
  logic [tlct_pkg::COL_W-1:0]  end_col_next;
  logic [tlct_pkg::LINE_W-1:0] first_kept_line_next;
  logic [tlct_pkg::KEPT_W-1:0] kept_line_count_next;
  logic [tlct_pkg::CNT_W-1:0]  char_count_next;
  logic                        range_error_next;

  logic                        accept;
  logic                        is_nl;
  logic                        full;
  logic [COUNT_BITS-1:0]       new_len;
  logic [tlct_pkg::WIDE_W-1:0] end_pos;
  logic [tlct_pkg::COL_W-1:0]  bc_latched;
  logic [tlct_pkg::LINE_W-1:0] bl_latched;
  logic [SLOT_W-1:0]           off_sel;
  logic [SLOT_W:0]             slot_sum;
  logic [SLOT_W-1:0]           mem_addr;
  logic                        mem_we;
  logic [COUNT_BITS-1:0]       mem_rdata;
  logic [tlct_pkg::LINE_W-1:0] kept_full;
  tlct_pkg::alu_in_t           alu_in;
  tlct_pkg::alu_out_t          alu_out;

  tlct_line_mem #(
    .DEPTH(HISTORY_LINES),
    .WIDTH(COUNT_BITS)
  ) u_line_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(new_len),
    .rdata(mem_rdata)
  );

  tlct_alu u_alu (
    .op (alu_in),
    .res(alu_out)
  );

  assign busy = (state != tlct_pkg::ST_IDLE);
  assign accept = start & ~busy;
  assign is_nl = (char_code == tlct_pkg::NL_CODE);
  assign full = (top_offset == LAST_OFF);
  assign new_len = (&cur_len) ? cur_len : cur_len + COUNT_BITS'(1);
  assign end_pos = tlct_pkg::WIDE_W'(new_len) - tlct_pkg::WIDE_W'(1);
  assign bc_latched = first_of_text ?
                      tlct_pkg::clamp16(tlct_pkg::WIDE_W'(cur_len) + tlct_pkg::WIDE_W'(1)) :
                      lat_col;
  assign bl_latched = first_of_text ? cur_line : lat_line;
  assign kept_full = tlct_pkg::LINE_W'(top_offset) + tlct_pkg::LINE_W'(1);

  // Physical slot of a line offset, counted from the oldest kept line.
  always_comb begin
    case (state)
      tlct_pkg::ST_SUM_RD: off_sel = idx;
      tlct_pkg::ST_RET_LOOP: off_sel = top_offset - SLOT_W'(1);
      default: off_sel = top_offset;
    endcase
    slot_sum = (SLOT_W + 1)'(oldest_slot) + (SLOT_W + 1)'(off_sel);
    mem_addr = (slot_sum >= DEPTH_X) ? SLOT_W'(slot_sum - DEPTH_X) : slot_sum[SLOT_W-1:0];
  end

  always_comb begin
    alu_in = '0;
    case (state)
      tlct_pkg::ST_IDLE: begin
        alu_in.b = tlct_pkg::WIDE_W'(cur_len);
      end
      tlct_pkg::ST_SUM_ADD: begin
        alu_in.a = tlct_pkg::WIDE_W'(acc);
        alu_in.b = tlct_pkg::WIDE_W'(mem_rdata);
      end
      tlct_pkg::ST_SUM_END: begin
        alu_in.sub = 1'b1;
        alu_in.a = tlct_pkg::WIDE_W'(acc);
        alu_in.b = tlct_pkg::WIDE_W'(rem);
      end
      tlct_pkg::ST_RET_LOOP: begin
        alu_in.sub = 1'b1;
        alu_in.a = tlct_pkg::WIDE_W'(cur_len);
        alu_in.b = tlct_pkg::WIDE_W'(rem);
      end
      default: begin
        alu_in = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    top_offset_next = top_offset;
    oldest_slot_next = oldest_slot;
    idx_next = idx;
    oldest_line_next = oldest_line;
    cur_line_next = cur_line;
    cur_len_next = cur_len;
    lat_line_next = lat_line;
    lat_col_next = lat_col;
    acc_next = acc;
    rem_next = rem;
    is_stat_next = is_stat;
    mem_we = 1'b0;

    result_valid_next = 1'b0;
    result_kind_next = tlct_pkg::KIND_LOC;
    begin_line_next = '0;
    begin_col_next = '0;
    end_line_next = '0;
    end_col_next = '0;
    first_kept_line_next = '0;
    kept_line_count_next = '0;
    char_count_next = '0;
    range_error_next = 1'b0;

    case (state)
      tlct_pkg::ST_IDLE: begin
        if (accept && action == tlct_pkg::ACT_ADVANCE) begin
          lat_line_next = bl_latched;
          lat_col_next = bc_latched;
          cur_len_next = new_len;
          if (is_nl) begin
            mem_we = 1'b1;
            cur_len_next = '0;
            cur_line_next = cur_line + tlct_pkg::LINE_W'(1);
            if (full) begin
              oldest_slot_next = (oldest_slot == LAST_OFF) ? '0 : oldest_slot + SLOT_W'(1);
              oldest_line_next = oldest_line + tlct_pkg::LINE_W'(1);
            end else begin
              top_offset_next = top_offset + SLOT_W'(1);
            end
          end
          if (last_of_text) begin
            result_valid_next = 1'b1;
            result_kind_next = tlct_pkg::KIND_LOC;
            begin_line_next = bl_latched;
            end_line_next = cur_line;
            if (is_nl) begin
              end_col_next = tlct_pkg::clamp16(end_pos);
              begin_col_next = (tlct_pkg::WIDE_W'(new_len) == tlct_pkg::WIDE_W'(bc_latched)) ?
                               tlct_pkg::clamp16(end_pos) : bc_latched;
            end else begin
              end_col_next = tlct_pkg::clamp16(tlct_pkg::WIDE_W'(new_len));
              begin_col_next = bc_latched;
            end
          end
        end else if (accept && (action == tlct_pkg::ACT_RETREAT ||
                                action == tlct_pkg::ACT_STAT)) begin
          acc_next = alu_out.sat_sum;
          idx_next = '0;
          rem_next = retreat_count;
          is_stat_next = (action == tlct_pkg::ACT_STAT);
          state_next = (top_offset == '0) ? tlct_pkg::ST_SUM_END : tlct_pkg::ST_SUM_RD;
        end
      end
      tlct_pkg::ST_SUM_RD: begin
        state_next = tlct_pkg::ST_SUM_ADD;
      end
      tlct_pkg::ST_SUM_ADD: begin
        acc_next = alu_out.sat_sum;
        idx_next = idx + SLOT_W'(1);
        state_next = (idx == top_offset - SLOT_W'(1)) ?
                     tlct_pkg::ST_SUM_END : tlct_pkg::ST_SUM_RD;
      end
      tlct_pkg::ST_SUM_END: begin
        if (is_stat) begin
          result_valid_next = 1'b1;
          result_kind_next = tlct_pkg::KIND_STAT;
          first_kept_line_next = oldest_line;
          kept_line_count_next = (kept_full > tlct_pkg::LINE_W'(tlct_pkg::KEPT_SAT)) ?
                                 tlct_pkg::KEPT_SAT : kept_full[tlct_pkg::KEPT_W-1:0];
          char_count_next = (acc > tlct_pkg::SUM_W'(tlct_pkg::CHAR_SAT)) ?
                            tlct_pkg::CHAR_SAT : acc[tlct_pkg::CNT_W-1:0];
          state_next = tlct_pkg::ST_IDLE;
        end else if (alu_out.borrow) begin
          result_valid_next = 1'b1;
          result_kind_next = tlct_pkg::KIND_RETREAT;
          range_error_next = 1'b1;
          state_next = tlct_pkg::ST_IDLE;
        end else begin
          state_next = tlct_pkg::ST_RET_LOOP;
        end
      end
      tlct_pkg::ST_RET_LOOP: begin
        if (rem == '0) begin
          result_valid_next = 1'b1;
          result_kind_next = tlct_pkg::KIND_RETREAT;
          state_next = tlct_pkg::ST_IDLE;
        end else if (cur_len == '0) begin
          if (top_offset == '0) begin
            result_valid_next = 1'b1;
            result_kind_next = tlct_pkg::KIND_RETREAT;
            range_error_next = 1'b1;
            state_next = tlct_pkg::ST_IDLE;
          end else begin
            top_offset_next = top_offset - SLOT_W'(1);
            cur_line_next = cur_line - tlct_pkg::LINE_W'(1);
            state_next = tlct_pkg::ST_RET_POP;
          end
        end else if (alu_out.borrow) begin
          cur_len_next = '0;
          rem_next = tlct_pkg::CNT_W'(tlct_pkg::WIDE_W'(0) - alu_out.diff);
        end else begin
          cur_len_next = COUNT_BITS'(alu_out.diff);
          rem_next = '0;
        end
      end
      tlct_pkg::ST_RET_POP: begin
        cur_len_next = mem_rdata;
        if (mem_rdata == '0) begin
          result_valid_next = 1'b1;
          result_kind_next = tlct_pkg::KIND_RETREAT;
          range_error_next = 1'b1;
          state_next = tlct_pkg::ST_IDLE;
        end else begin
          state_next = tlct_pkg::ST_RET_LOOP;
        end
      end
      default: begin
        state_next = tlct_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlct_pkg::ST_IDLE;
      top_offset <= '0;
      oldest_slot <= '0;
      oldest_line <= tlct_pkg::LINE_W'(1);
      cur_line <= tlct_pkg::LINE_W'(1);
      cur_len <= '0;
      lat_line <= '0;
      lat_col <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      top_offset <= top_offset_next;
      oldest_slot <= oldest_slot_next;
      oldest_line <= oldest_line_next;
      cur_line <= cur_line_next;
      cur_len <= cur_len_next;
      lat_line <= lat_line_next;
      lat_col <= lat_col_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    acc <= acc_next;
    rem <= rem_next;
    is_stat <= is_stat_next;
    result_kind <= result_kind_next;
    begin_line <= begin_line_next;
    begin_col <= begin_col_next;
    end_line <= end_line_next;
    end_col <= end_col_next;
    first_kept_line <= first_kept_line_next;
    kept_line_count <= kept_line_count_next;
    char_count <= char_count_next;
    range_error <= range_error_next;
  end

endmodule

// ----- sim/tlct_location_checker.sv -----
module tlct_location_checker
  import tlct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        action,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              first_of_text,
  input  logic              last_of_text,
  input  logic [CNT_W-1:0]  retreat_count,
  input  logic              result_valid,
  input  logic [KIND_W-1:0] result_kind,
  input  logic [LINE_W-1:0] begin_line,
  input  logic [COL_W-1:0]  begin_col,
  input  logic [LINE_W-1:0] end_line,
  input  logic [COL_W-1:0]  end_col,
  input  logic [LINE_W-1:0] first_kept_line,
  input  logic [KEPT_W-1:0] kept_line_count,
  input  logic [CNT_W-1:0]  char_count,
  input  logic              range_error,
  output int                errors,
  output int                pending
);

  localparam int DEPTH = HISTORY_LINES_DEF;
  localparam longint unsigned LEN_MAX = (64'd1 << COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] b_line;
    logic [COL_W-1:0]  b_col;
    logic [LINE_W-1:0] e_line;
    logic [COL_W-1:0]  e_col;
    logic [LINE_W-1:0] first_line;
    logic [KEPT_W-1:0] line_cnt;
    logic [CNT_W-1:0]  chars;
    logic              err;
  } position_report_t;

  position_report_t report_q[$];
  position_report_t want_r;

  int unsigned       line_len [DEPTH];
  int unsigned       oldest_slot;
  int unsigned       top_off;
  logic [LINE_W-1:0] oldest_line;
  logic [LINE_W-1:0] latch_line;
  logic [COL_W-1:0]  latch_col;
  int                fail_cnt = 0;

  function automatic int unsigned slot_at(input int unsigned off);
    return (oldest_slot + off) % DEPTH;
  endfunction

  function automatic logic [COL_W-1:0] sat_col(input longint unsigned v);
    return (v > COL_SAT) ? COL_SAT : COL_W'(v);
  endfunction

  function automatic longint unsigned kept_chars();
    longint unsigned s;
    int unsigned i;
    s = 0;
    for (i = 0; i <= top_off && i < DEPTH; i++) begin
      s += line_len[slot_at(i)];
    end
    return s;
  endfunction

  task automatic clear_positions();
    int i;
    for (i = 0; i < DEPTH; i++) begin
      line_len[i] = 0;
    end
    oldest_slot = 0;
    top_off = 0;
    oldest_line = 1;
    latch_line = '0;
    latch_col = '0;
  endtask

  task automatic open_line();
    if (top_off >= DEPTH - 1) begin
      oldest_slot = (oldest_slot + 1) % DEPTH;
      oldest_line = oldest_line + 1;
      top_off = DEPTH - 1;
    end else begin
      top_off++;
    end
    line_len[slot_at(top_off)] = 0;
  endtask

  task automatic track_item(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                            input logic fst, input logic lst,
                            input logic [CNT_W-1:0] cnt);
    position_report_t r;
    int unsigned cur;
    int unsigned prv;
    int unsigned plen;
    int unsigned remaining;
    int unsigned take;
    longint unsigned ecol;
    longint unsigned sum;
    logic nl;
    r = '0;
    case (act)
      ACT_ADVANCE: begin
        cur = slot_at(top_off);
        nl = (ch == NL_CODE);
        if (fst) begin
          latch_line = oldest_line + top_off;
          latch_col = sat_col(longint'(line_len[cur]) + 1);
        end
        if (line_len[cur] < LEN_MAX) line_len[cur]++;
        if (nl) open_line();
        if (lst) begin
          r.kind = KIND_LOC;
          r.b_line = latch_line;
          r.b_col = latch_col;
          if (!nl) begin
            r.e_line = oldest_line + top_off;
            r.e_col = sat_col(line_len[slot_at(top_off)]);
          end else begin
            // A token ending in a newline ends on the previous line, before the newline.
            prv = (top_off > 0) ? top_off - 1 : 0;
            plen = line_len[slot_at(prv)];
            ecol = (plen > 0) ? plen - 1 : 0;
            r.e_line = oldest_line + prv;
            if (ecol + 1 == latch_col) r.b_col = sat_col(ecol);
            r.e_col = sat_col(ecol);
          end
          report_q.push_back(r);
        end
      end
      ACT_RETREAT: begin
        r.kind = KIND_RETREAT;
        sum = kept_chars();
        if (cnt > sum) begin
          r.err = 1'b1;
        end else begin
          cur = slot_at(top_off);
          remaining = cnt;
          while (remaining > 0 && !r.err) begin
            if (line_len[cur] == 0) begin
              if (top_off == 0) begin
                r.err = 1'b1;
              end else begin
                top_off--;
                cur = slot_at(top_off);
                if (line_len[cur] == 0) r.err = 1'b1;
              end
            end
            if (!r.err) begin
              take = (line_len[cur] < remaining) ? line_len[cur] : remaining;
              line_len[cur] -= take;
              remaining -= take;
            end
          end
        end
        report_q.push_back(r);
      end
      ACT_STAT: begin
        r.kind = KIND_STAT;
        sum = kept_chars();
        r.first_line = oldest_line;
        r.line_cnt = (top_off + 1 > KEPT_SAT) ? KEPT_SAT : KEPT_W'(top_off + 1);
        r.chars = (sum > CHAR_SAT) ? CHAR_SAT : CNT_W'(sum);
        report_q.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_positions();
      report_q.delete();
    end else begin
      if (result_valid) begin
        if (report_q.size() == 0) begin
          $error("result transfer of kind %0d with nothing expected", result_kind);
          fail_cnt++;
        end else begin
          want_r = report_q.pop_front();
          check_field("result_kind", want_r.kind, result_kind);
          check_field("begin_line", want_r.b_line, begin_line);
          check_field("begin_col", want_r.b_col, begin_col);
          check_field("end_line", want_r.e_line, end_line);
          check_field("end_col", want_r.e_col, end_col);
          check_field("first_kept_line", want_r.first_line, first_kept_line);
          check_field("kept_line_count", want_r.line_cnt, kept_line_count);
          check_field("char_count", want_r.chars, char_count);
          check_field("range_error", want_r.err, range_error);
        end
      end
      if (start && !busy) begin
        track_item(action, char_code, first_of_text, last_of_text, retreat_count);
      end
    end
    pending <= report_q.size();
    errors <= fail_cnt;
  end

endmodule

// ----- sim/tb_text_line_column_tracker_unit.sv -----
module tb_text_line_column_tracker_unit;
  import tlct_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int LONG_LINE = 200;
  localparam logic [CNT_W-1:0] RETREAT_MAX = 20'd1048560;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        action = ACT_ADVANCE;
  logic [CHAR_W-1:0] char_code = '0;
  logic              first_of_text = 1'b0;
  logic              last_of_text = 1'b0;
  logic [CNT_W-1:0]  retreat_count = '0;
  logic              result_valid;
  logic [KIND_W-1:0] result_kind;
  logic [LINE_W-1:0] begin_line;
  logic [COL_W-1:0]  begin_col;
  logic [LINE_W-1:0] end_line;
  logic [COL_W-1:0]  end_col;
  logic [LINE_W-1:0] first_kept_line;
  logic [KEPT_W-1:0] kept_line_count;
  logic [CNT_W-1:0]  char_count;
  logic              range_error;

  int fail_count;
  int pending_count;
  int cycle_cnt = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;

  text_line_column_tracker_unit dut (.*);

  tlct_location_checker loc_chk (.*, .errors(fail_count), .pending(pending_count));

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                           input logic fst, input logic lst,
                           input logic [CNT_W-1:0] cnt);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    char_code <= ch;
    first_of_text <= fst;
    last_of_text <= lst;
    retreat_count <= cnt;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [CHAR_W-1:0] text_char(input bit nl_heavy);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < (nl_heavy ? 4 : 1)) return NL_CODE;
    if (pick < 6) return CHAR_W'($urandom_range(0, 255));
    return CHAR_W'($urandom_range(8'h21, 8'h7e));
  endfunction

  initial begin
    int n;
    int i;
    int len;
    int sel;
    logic [CNT_W-1:0] cnt;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(ACT_STAT, 8'h00, 1'b0, 1'b0, 20'd0);
    send_item(ACT_RETREAT, 8'hff, 1'b1, 1'b1, 20'd0);
    send_item(ACT_RETREAT, 8'h00, 1'b0, 1'b0, 20'd1);
    send_item(ACT_ADVANCE, 8'h61, 1'b1, 1'b0, RETREAT_MAX);
    send_item(ACT_ADVANCE, 8'hff, 1'b0, 1'b0, 20'd0);
    send_item(ACT_ADVANCE, 8'h00, 1'b0, 1'b1, 20'hfffff);
    send_item(ACT_ADVANCE, NL_CODE, 1'b1, 1'b1, 20'd0);
    send_item(ACT_ADVANCE, 8'h78, 1'b1, 1'b1, 20'd0);
    send_item(ACT_ADVANCE, 8'h79, 1'b0, 1'b1, 20'd0);
    send_item(ACT_ADVANCE, 8'h62, 1'b1, 1'b0, 20'd0);
    send_item(ACT_ADVANCE, NL_CODE, 1'b0, 1'b1, 20'd0);
    send_item(2'd3, 8'h5a, 1'b1, 1'b1, 20'habcde);
    send_item(ACT_STAT, 8'h00, 1'b0, 1'b0, 20'd0);
    send_item(ACT_RETREAT, 8'h00, 1'b0, 1'b0, 20'd3);
    send_item(ACT_STAT, 8'h00, 1'b0, 1'b0, 20'd0);
    send_item(ACT_RETREAT, 8'h00, 1'b0, 1'b0, RETREAT_MAX);
    send_item(ACT_ADVANCE, NL_CODE, 1'b1, 1'b1, 20'd0);
    send_item(ACT_STAT, 8'h00, 1'b0, 1'b0, 20'd0);

    // One long line sent back to back, with tokens starting near its end.
    no_gaps = 1'b1;
    for (i = 0; i < LONG_LINE; i++) begin
      send_item(ACT_ADVANCE, 8'h2d, i == LONG_LINE - 6 || i == LONG_LINE - 4, 1'b0,
                CNT_W'($urandom));
    end
    no_gaps = 1'b0;
    send_item(ACT_STAT, 8'h00, 1'b0, 1'b0, 20'd0);
    send_item(ACT_ADVANCE, 8'h7a, 1'b0, 1'b1, 20'd0);
    send_item(ACT_ADVANCE, NL_CODE, 1'b0, 1'b1, 20'd0);
    send_item(ACT_RETREAT, 8'h00, 1'b0, 1'b0, 20'd70000);
    send_item(ACT_STAT, 8'h00, 1'b0, 1'b0, 20'd0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
          send_item(ACT_ADVANCE, text_char(i == len - 1), i == 0, i == len - 1,
                    CNT_W'($urandom));
          n++;
        end
      end else if (sel < 72) begin
        send_item(ACT_STAT, CHAR_W'($urandom), 1'($urandom), 1'($urandom),
                  CNT_W'($urandom));
        n++;
      end else if (sel < 86) begin
        case ($urandom_range(0, 9))
          0: cnt = CNT_W'($urandom_range(0, RETREAT_MAX));
          1, 2: cnt = CNT_W'($urandom_range(0, 400));
          default: cnt = CNT_W'($urandom_range(0, 12));
        endcase
        send_item(ACT_RETREAT, CHAR_W'($urandom), 1'($urandom), 1'($urandom), cnt);
        n++;
      end else if (sel < 97) begin
        send_item(ACT_ADVANCE, CHAR_W'($urandom), 1'($urandom), 1'($urandom),
                  CNT_W'($urandom));
        n++;
      end else begin
        send_item(2'd3, CHAR_W'($urandom), 1'($urandom), 1'($urandom), CNT_W'($urandom));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
